/* src/fcet_pkg.sv */
package fcet_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CODE_W   = 32;
  localparam int STATUS_W = 8;
  localparam int OCC_W    = 16;
  localparam int AGE_W    = 16;
  localparam int CFG_W    = 5;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_GET    = 3'd1,
    OP_CLEAR1 = 3'd2,
    OP_CLRALL = 3'd3,
    OP_AGE    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
    logic [AGE_W-1:0]    aging;
  } entry_t;

  localparam logic [OCC_W-1:0] OCC_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

endpackage

/* src/fault_code_event_table.sv */
// fault code event table: up to CAPACITY (16) entries keyed by a 32-bit code,
// holding status, occurrence and aging counters in a single-port-read memory.
// store, get, clear one and apply aging walk the whole table through the one
// memory read port, one entry a cycle with registered read data, before their
// result is formed; clear all and unused opcodes go straight to the result
// without a scan. the input is ready again in the cycle the result appears, so
// no new item is accepted while an item is still scanning the table.
// valid bits live in flip-flops and are cleared by reset at once, so no clearing
// pass is needed. one result item per input item; the next item is accepted
// while a result still waits on the output side, and its result is held back
// until the previous one is taken.
// max_entries (apb offset 0) sets the fill level at which a new code first
// displaces the entry with the fewest occurrences (lowest code on ties) and
// sets overflow; 0 acts as 1 and values above CAPACITY act as CAPACITY.
module fault_code_event_table (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // dtc_code[31:0], status_in[39:32], aging_threshold[55:40]
  input  logic [2:0]  s_tuser,   // opcode[2:0]

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status_out[7:0], occurrences_out[23:8], aging_out[39:24],
                                 // entry_count[44:40], overflow[45], zero fill above
  output logic        m_tuser,   // result_code

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP   = fcet_pkg::CAPACITY;
  localparam int IDX_W = fcet_pkg::IDX_W;
  localparam int CNT_W = fcet_pkg::CNT_W;

  // configuration
  logic [fcet_pkg::CFG_W-1:0] max_entries;
  logic [CNT_W-1:0]           lim;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-fcet_pkg::CFG_W){1'b0}}, max_entries} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= fcet_pkg::CFG_W'(CAP > 16 ? 16 : CAP);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_entries <= pwdata[fcet_pkg::CFG_W-1:0];
    end
  end

  // effective fill limit
  always_comb begin
    if (max_entries == '0) begin
      lim = CNT_W'(1);
    end else if (32'(max_entries) > CAP) begin
      lim = CNT_W'(CAP);
    end else begin
      lim = CNT_W'(max_entries);
    end
  end

  // control and item registers
  fcet_pkg::state_t  state, state_next;
  fcet_pkg::opcode_t op;
  logic [fcet_pkg::CODE_W-1:0]   key;
  logic [fcet_pkg::STATUS_W-1:0] status_q;
  logic [fcet_pkg::AGE_W-1:0]    thr;

  logic [CAP-1:0]   valid;
  logic [CNT_W-1:0] count;
  logic             overflow_flag;

  // scan bookkeeping
  logic [IDX_W-1:0] scan_idx;
  logic             issue_done;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  fcet_pkg::entry_t hit;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [fcet_pkg::OCC_W-1:0]  best_occ;
  logic [fcet_pkg::CODE_W-1:0] best_code;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // entry memory
  fcet_pkg::entry_t mem [CAP];
  fcet_pkg::entry_t rd_data;
  fcet_pkg::entry_t mem_wdata;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  logic accept, fin_go, rd_live;
  logic [fcet_pkg::AGE_W-1:0] rd_age_inc;
  logic [fcet_pkg::OCC_W-1:0] hit_occ_inc;
  logic age_kill, full, better;
  logic [IDX_W-1:0] ins_slot;
  logic [CAP-1:0]   valid_ins;

  // result fields
  logic [CNT_W-1:0] count_res;
  logic             ovf_res;
  logic [47:0]      res_data;
  logic             res_user;

  assign s_tready = (state == fcet_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fin_go   = (state == fcet_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  // returned read data of a valid entry
  assign rd_live  = (state == fcet_pkg::ST_SCAN) && rd_pend && valid[rd_idx];

  assign rd_age_inc  = (rd_data.aging == fcet_pkg::AGE_MAX) ? rd_data.aging
                                                            : rd_data.aging + 1'b1;
  assign age_kill    = (rd_age_inc >= thr);
  assign hit_occ_inc = (hit.occ == fcet_pkg::OCC_MAX) ? hit.occ : hit.occ + 1'b1;
  assign full        = (count >= lim);
  assign better      = !best_found || (rd_data.occ < best_occ) ||
                       ((rd_data.occ == best_occ) && (rd_data.code < best_code));

  // after a displacement the lowest free slot is either an old hole or the victim
  assign ins_slot = !full ? free_idx :
                    (free_found && (free_idx < best_idx)) ? free_idx : best_idx;

  // valid bits after a store of a new code: victim out, new entry in
  always_comb begin
    valid_ins = valid;
    if (full) begin
      valid_ins[best_idx] = 1'b0;
    end
    valid_ins[ins_slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = scan_idx;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx;
    mem_wdata  = '{code: rd_data.code, status: rd_data.status,
                   occ: rd_data.occ, aging: rd_age_inc};
    case (state)
      fcet_pkg::ST_IDLE: begin
        if (accept) begin
          case (fcet_pkg::opcode_t'(s_tuser))
            fcet_pkg::OP_STORE, fcet_pkg::OP_GET,
            fcet_pkg::OP_CLEAR1, fcet_pkg::OP_AGE: state_next = fcet_pkg::ST_SCAN;
            default: state_next = fcet_pkg::ST_FINISH;
          endcase
        end
      end
      fcet_pkg::ST_SCAN: begin
        mem_re = !issue_done;
        // aging write-back trails the read by one entry, so the two never collide
        if (rd_live && (op == fcet_pkg::OP_AGE) && !age_kill) begin
          mem_we = 1'b1;
        end
        if (issue_done && !rd_pend) begin
          state_next = fcet_pkg::ST_FINISH;
        end
      end
      fcet_pkg::ST_FINISH: begin
        if (fin_go) begin
          state_next = fcet_pkg::ST_IDLE;
          if (op == fcet_pkg::OP_STORE) begin
            mem_we = 1'b1;
            if (found) begin
              mem_waddr = hit_idx;
              mem_wdata = '{code: key, status: status_q, occ: hit_occ_inc, aging: '0};
            end else begin
              mem_waddr = ins_slot;
              mem_wdata = '{code: key, status: status_q,
                            occ: fcet_pkg::OCC_W'(1), aging: '0};
            end
          end
        end
      end
      default: state_next = fcet_pkg::ST_IDLE;
    endcase
  end

  // datapath, valid bits and counters
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= fcet_pkg::opcode_t'(s_tuser);
      key      <= s_tdata[31:0];
      status_q <= s_tdata[39:32];
      thr      <= s_tdata[55:40];
      scan_idx   <= '0;
      issue_done <= 1'b0;
      found      <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == fcet_pkg::ST_SCAN) begin
      if (!issue_done) begin
        rd_idx <= scan_idx;
        if (scan_idx == IDX_W'(CAP - 1)) begin
          issue_done <= 1'b1;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (rd_pend) begin
        if (!valid[rd_idx]) begin
          if (!free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
        end else begin
          if (!found && (rd_data.code == key)) begin
            found   <= 1'b1;
            hit_idx <= rd_idx;
            hit     <= rd_data;
          end
          if (better) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_occ   <= rd_data.occ;
            best_code  <= rd_data.code;
          end
        end
      end
    end
    if (fin_go) begin
      m_tuser <= res_user;
      m_tdata <= res_data;
    end

    if (rst) begin
      valid         <= '0;
      count         <= '0;
      overflow_flag <= 1'b0;
      rd_pend       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      rd_pend <= (state == fcet_pkg::ST_SCAN) && !issue_done;
      if (rd_live && (op == fcet_pkg::OP_AGE) && age_kill) begin
        valid[rd_idx] <= 1'b0;
        count         <= count - 1'b1;
      end
      if (fin_go) begin
        m_tvalid <= 1'b1;
        case (op)
          fcet_pkg::OP_STORE: begin
            if (!found) begin
              if (full) begin
                overflow_flag <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
              valid <= valid_ins;
            end
          end
          fcet_pkg::OP_CLEAR1: begin
            if (found) begin
              valid[hit_idx] <= 1'b0;
              count          <= count - 1'b1;
            end
          end
          fcet_pkg::OP_CLRALL: begin
            valid         <= '0;
            count         <= '0;
            overflow_flag <= 1'b0;
          end
          default: ;
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // count and overflow reflect the table after the item's own update
  always_comb begin
    count_res = count;
    ovf_res   = overflow_flag;
    case (op)
      fcet_pkg::OP_STORE: begin
        if (!found) begin
          if (full) begin
            ovf_res = 1'b1;
          end else begin
            count_res = count + 1'b1;
          end
        end
      end
      fcet_pkg::OP_CLEAR1: begin
        if (found) begin
          count_res = count - 1'b1;
        end
      end
      fcet_pkg::OP_CLRALL: begin
        count_res = '0;
        ovf_res   = 1'b0;
      end
      default: ;
    endcase
  end

  // result item: entry fields only on a successful get
  always_comb begin
    res_user = 1'b0;
    res_data = '0;
    case (op)
      fcet_pkg::OP_GET: begin
        if (found) begin
          res_data[7:0]   = hit.status;
          res_data[23:8]  = hit.occ;
          res_data[39:24] = hit.aging;
        end else begin
          res_user = 1'b1;
        end
      end
      fcet_pkg::OP_CLEAR1: res_user = !found;
      default: ;
    endcase
    res_data[44:40] = fcet_pkg::CNT_OUT_W'(count_res);
    res_data[45]    = ovf_res;
  end

  // assertions
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(valid))
    else $error("entry count out of step with valid bits");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory write and read hit the same entry");

  a_clear_all_empties: assert property (@(posedge clk) disable iff (rst)
    (fin_go && (op == fcet_pkg::OP_CLRALL)) |=> ((valid == '0) && !overflow_flag))
    else $error("clear all left entries or overflow behind");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule
